FILE: hw/rtl/mgsa_pkg.sv
// Shared constants, codes and control types of the max-gap seat allocator.
`timescale 1ns / 1ps

package mgsa_pkg;

    localparam int SEATS  = 1024;
    localparam int WORD_W = 16;
    localparam int WORDS  = SEATS / WORD_W;
    localparam int SEAT_W = $clog2(SEATS);
    localparam int CNT_W  = SEAT_W + 1;
    localparam int ROW_W  = $clog2(WORDS);
    localparam int OFF_W  = $clog2(WORD_W);
    localparam int GAP_W  = OFF_W - 1;

    typedef enum logic {
        FUNC_SEAT  = 1'b0,
        FUNC_LEAVE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_FREE = 2'd2
    } t_status;

    typedef struct packed {
        logic load_item;
        logic scan_init;
        logic scan_rd;
        logic lv_rd;
        logic lv_chk;
        logic fin;
        logic seat_rd;
        logic seat_wr;
        logic res_full;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_leave;
        logic scan_last;
        logic pipe_busy;
        logic full;
    } t_stat;

endpackage

FILE: hw/rtl/mgsa_datapath.sv
// Datapath: occupancy memory, word scan pipeline, gap tracking and result registers.
`timescale 1ns / 1ps

module mgsa_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mgsa_pkg::CNT_W-1:0]  i_cfg_data,
    input  mgsa_pkg::t_func             i_item_func,
    input  logic [mgsa_pkg::SEAT_W-1:0] i_item_pos,
    input  mgsa_pkg::t_cmd              i_cmd,
    output mgsa_pkg::t_stat             o_stat,
    output logic [mgsa_pkg::SEAT_W-1:0] o_out_seat,
    output mgsa_pkg::t_status           o_out_status
);

    logic [mgsa_pkg::CNT_W-1:0]  r_seat_count;
    mgsa_pkg::t_func             r_func;
    logic [mgsa_pkg::SEAT_W-1:0] r_pos;

    logic [mgsa_pkg::WORD_W-1:0] r_mem [mgsa_pkg::WORDS];
    logic [mgsa_pkg::WORDS-1:0]  r_row_valid;
    logic [mgsa_pkg::WORD_W-1:0] r_rd_word;
    logic                        r_rd_vld;
    logic [mgsa_pkg::ROW_W-1:0]  r_rd_idx;
    logic                        r_rd_act;
    logic [mgsa_pkg::ROW_W-1:0]  r_scan_idx;

    logic                        r_sum_act;
    logic                        r_sum_any;
    logic [mgsa_pkg::OFF_W-1:0]  r_sum_first;
    logic [mgsa_pkg::OFF_W-1:0]  r_sum_last;
    logic [mgsa_pkg::GAP_W-1:0]  r_sum_gap;
    logic [mgsa_pkg::OFF_W-1:0]  r_sum_off;
    logic [mgsa_pkg::ROW_W-1:0]  r_sum_idx;

    logic                        r_have_prev;
    logic [mgsa_pkg::SEAT_W-1:0] r_prev;
    logic [mgsa_pkg::CNT_W-1:0]  r_best_d;
    logic [mgsa_pkg::SEAT_W-1:0] r_best_seat;
    logic [mgsa_pkg::SEAT_W-1:0] r_fin_seat;
    logic                        r_full;

    logic [mgsa_pkg::SEAT_W-1:0] r_res_seat;
    mgsa_pkg::t_status           r_res_status;
    logic [mgsa_pkg::SEAT_W-1:0] r_out_seat;
    mgsa_pkg::t_status           r_out_status;

    logic [mgsa_pkg::CNT_W-1:0]  n_eff;
    logic [mgsa_pkg::SEAT_W-1:0] nm1;
    logic [mgsa_pkg::ROW_W-1:0]  last_row;
    logic                        rd_en;
    logic [mgsa_pkg::ROW_W-1:0]  rd_row;
    logic [mgsa_pkg::WORD_W-1:0] eff_word;
    logic [mgsa_pkg::WORD_W-1:0] scan_mask;
    logic [mgsa_pkg::WORD_W-1:0] scan_word;
    logic                        w_any;
    logic [mgsa_pkg::OFF_W-1:0]  w_first;
    logic [mgsa_pkg::OFF_W-1:0]  w_last;
    logic [mgsa_pkg::GAP_W-1:0]  t_d [mgsa_pkg::WORD_W];
    logic [mgsa_pkg::OFF_W-1:0]  t_o [mgsa_pkg::WORD_W];

    logic [mgsa_pkg::SEAT_W-1:0] f_pos;
    logic [mgsa_pkg::SEAT_W-1:0] cross_diff;
    logic [mgsa_pkg::CNT_W-1:0]  cross_sum;
    logic [mgsa_pkg::CNT_W-1:0]  cross_d;
    logic [mgsa_pkg::SEAT_W-1:0] cross_seat;
    logic [mgsa_pkg::CNT_W-1:0]  b1_d;
    logic [mgsa_pkg::SEAT_W-1:0] b1_seat;
    logic [mgsa_pkg::CNT_W-1:0]  b2_d;
    logic [mgsa_pkg::SEAT_W-1:0] b2_seat;

    logic [mgsa_pkg::CNT_W-1:0]  edge_d;
    logic [mgsa_pkg::SEAT_W-1:0] edge_seat;
    logic                        lv_ok;
    logic                        wr_en;
    logic [mgsa_pkg::ROW_W-1:0]  wr_row;
    logic [mgsa_pkg::WORD_W-1:0] wr_data;

    // Effective row length, limited to one seat at least and the full row at most.
    always_comb begin
        if (r_seat_count == '0) begin
            n_eff = mgsa_pkg::CNT_W'(1);
        end else if (r_seat_count > mgsa_pkg::CNT_W'(mgsa_pkg::SEATS)) begin
            n_eff = mgsa_pkg::CNT_W'(mgsa_pkg::SEATS);
        end else begin
            n_eff = r_seat_count;
        end
    end

    assign nm1      = mgsa_pkg::SEAT_W'(n_eff - mgsa_pkg::CNT_W'(1));
    assign last_row = nm1[mgsa_pkg::SEAT_W-1:mgsa_pkg::OFF_W];

    always_comb begin
        rd_en  = i_cmd.scan_rd || i_cmd.lv_rd || i_cmd.seat_rd;
        rd_row = r_scan_idx;
        if (i_cmd.lv_rd) begin
            rd_row = r_pos[mgsa_pkg::SEAT_W-1:mgsa_pkg::OFF_W];
        end else if (i_cmd.seat_rd) begin
            rd_row = r_fin_seat[mgsa_pkg::SEAT_W-1:mgsa_pkg::OFF_W];
        end
    end

    // A row never written since reset reads as all seats free.
    assign eff_word = r_rd_vld ? r_rd_word : '0;

    always_comb begin
        for (int j = 0; j < mgsa_pkg::WORD_W; j++) begin
            scan_mask[j] = (r_rd_idx != last_row) ||
                           (mgsa_pkg::OFF_W'(j) <= nm1[mgsa_pkg::OFF_W-1:0]);
        end
    end

    assign scan_word = eff_word & scan_mask;

    always_comb begin
        w_any   = 1'b0;
        w_first = '0;
        w_last  = '0;
        for (int j = mgsa_pkg::WORD_W - 1; j >= 0; j--) begin
            if (scan_word[j]) begin
                w_first = mgsa_pkg::OFF_W'(j);
            end
        end
        for (int j = 0; j < mgsa_pkg::WORD_W; j++) begin
            if (scan_word[j]) begin
                w_any  = 1'b1;
                w_last = mgsa_pkg::OFF_W'(j);
            end
        end
    end

    // Widest gap between occupied seats inside the word; the tree keeps the lower one on a tie.
    always_comb begin
        logic found;
        int   kk;
        found = 1'b0;
        kk    = 0;
        for (int j = 0; j < mgsa_pkg::WORD_W; j++) begin
            found  = 1'b0;
            kk     = 0;
            t_d[j] = '0;
            t_o[j] = '0;
            for (int k = 0; k < j; k++) begin
                if (scan_word[k]) begin
                    found = 1'b1;
                    kk    = k;
                end
            end
            if (scan_word[j] && found) begin
                t_d[j] = mgsa_pkg::GAP_W'((j - kk) >> 1);
                t_o[j] = mgsa_pkg::OFF_W'((j + kk) >> 1);
            end
        end
        for (int s = 1; s < mgsa_pkg::WORD_W; s = s * 2) begin
            for (int i = 0; i < mgsa_pkg::WORD_W; i = i + 2 * s) begin
                if (t_d[i + s] > t_d[i]) begin
                    t_d[i] = t_d[i + s];
                    t_o[i] = t_o[i + s];
                end
            end
        end
    end

    // Gap from the last occupied seat so far to this word's first; keeps the widest gap.
    always_comb begin
        f_pos      = {r_sum_idx, r_sum_first};
        cross_diff = f_pos - r_prev;
        cross_sum  = {1'b0, r_prev} + {1'b0, f_pos};
        if (r_have_prev) begin
            cross_d    = mgsa_pkg::CNT_W'(cross_diff >> 1);
            cross_seat = cross_sum[mgsa_pkg::SEAT_W:1];
        end else begin
            cross_d    = {1'b0, f_pos};
            cross_seat = '0;
        end
        b1_d    = r_best_d;
        b1_seat = r_best_seat;
        if (cross_d > r_best_d) begin
            b1_d    = cross_d;
            b1_seat = cross_seat;
        end
        b2_d    = b1_d;
        b2_seat = b1_seat;
        if (mgsa_pkg::CNT_W'(r_sum_gap) > b1_d) begin
            b2_d    = mgsa_pkg::CNT_W'(r_sum_gap);
            b2_seat = {r_sum_idx, r_sum_off};
        end
    end

    always_comb begin
        if (r_have_prev) begin
            edge_d    = {1'b0, nm1} - {1'b0, r_prev};
            edge_seat = nm1;
        end else begin
            edge_d    = n_eff;
            edge_seat = '0;
        end
    end

    always_comb begin
        lv_ok = ({1'b0, r_pos} < n_eff) && eff_word[r_pos[mgsa_pkg::OFF_W-1:0]];
        wr_en = (i_cmd.lv_chk && lv_ok) || i_cmd.seat_wr;
        if (i_cmd.seat_wr) begin
            wr_row  = r_fin_seat[mgsa_pkg::SEAT_W-1:mgsa_pkg::OFF_W];
            wr_data = eff_word |
                      (mgsa_pkg::WORD_W'(1) << r_fin_seat[mgsa_pkg::OFF_W-1:0]);
        end else begin
            wr_row  = r_pos[mgsa_pkg::SEAT_W-1:mgsa_pkg::OFF_W];
            wr_data = eff_word &
                      ~(mgsa_pkg::WORD_W'(1) << r_pos[mgsa_pkg::OFF_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_row] <= wr_data;
        end
        if (rd_en) begin
            r_rd_word <= r_mem[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat_count <= mgsa_pkg::CNT_W'(mgsa_pkg::SEATS);
            r_row_valid  <= '0;
            r_rd_act     <= 1'b0;
            r_sum_act    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seat_count <= i_cfg_data;
            end
            if (wr_en) begin
                r_row_valid[wr_row] <= 1'b1;
            end
            r_rd_act  <= i_cmd.scan_rd;
            r_sum_act <= r_rd_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func <= i_item_func;
            r_pos  <= i_item_pos;
        end
        if (rd_en) begin
            r_rd_vld <= r_row_valid[rd_row];
            r_rd_idx <= rd_row;
        end
        if (i_cmd.scan_init) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_rd) begin
            r_scan_idx <= r_scan_idx + mgsa_pkg::ROW_W'(1);
        end
        r_sum_any   <= w_any;
        r_sum_first <= w_first;
        r_sum_last  <= w_last;
        r_sum_gap   <= t_d[0];
        r_sum_off   <= t_o[0];
        r_sum_idx   <= r_rd_idx;
        if (i_cmd.scan_init) begin
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_best_d    <= '0;
            r_best_seat <= '0;
        end else if (r_sum_act && r_sum_any) begin
            r_have_prev <= 1'b1;
            r_prev      <= {r_sum_idx, r_sum_last};
            r_best_d    <= b2_d;
            r_best_seat <= b2_seat;
        end
        if (i_cmd.fin) begin
            if (edge_d > r_best_d) begin
                r_fin_seat <= edge_seat;
            end else begin
                r_fin_seat <= r_best_seat;
            end
            r_full <= (edge_d == '0) && (r_best_d == '0);
        end
        if (i_cmd.lv_chk) begin
            r_res_seat   <= '0;
            r_res_status <= lv_ok ? mgsa_pkg::STATUS_OK : mgsa_pkg::STATUS_FREE;
        end else if (i_cmd.seat_wr) begin
            r_res_seat   <= r_fin_seat;
            r_res_status <= mgsa_pkg::STATUS_OK;
        end else if (i_cmd.res_full) begin
            r_res_seat   <= '0;
            r_res_status <= mgsa_pkg::STATUS_FULL;
        end
        if (i_cmd.out_load) begin
            r_out_seat   <= r_res_seat;
            r_out_status <= r_res_status;
        end
    end

    always_comb begin
        o_stat.is_leave  = (r_func == mgsa_pkg::FUNC_LEAVE);
        o_stat.scan_last = (r_scan_idx == last_row);
        o_stat.pipe_busy = r_rd_act || r_sum_act;
        o_stat.full      = r_full;
    end

    assign o_out_seat   = r_out_seat;
    assign o_out_status = r_out_status;

    a_sum_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_act |-> $past(r_rd_act))
        else $error("Scan summary stage active without a preceding read.");

    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_act |=> (r_best_d >= $past(r_best_d)))
        else $error("Best gap distance shrank during a scan.");

    a_seat_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seat_wr |-> ({1'b0, r_fin_seat} < n_eff))
        else $error("Seat written outside the active row.");

endmodule

FILE: hw/rtl/mgsa_ctrl.sv
// Controller state machine that sequences leave checks and seat scans.
`timescale 1ns / 1ps

module mgsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mgsa_pkg::t_stat i_stat,
    output mgsa_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LV_RD,
        S_LV_CHK,
        S_SC_RUN,
        S_SC_DRAIN,
        S_SC_FIN,
        S_SC_DECIDE,
        S_SC_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_leave) begin
                    n_state = S_LV_RD;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SC_RUN;
                end
            end
            S_LV_RD: begin
                o_cmd.lv_rd = 1'b1;
                n_state     = S_LV_CHK;
            end
            S_LV_CHK: begin
                o_cmd.lv_chk = 1'b1;
                n_state      = S_DONE;
            end
            S_SC_RUN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SC_DRAIN;
                end
            end
            S_SC_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_SC_FIN;
                end
            end
            S_SC_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_SC_DECIDE;
            end
            S_SC_DECIDE: begin
                if (i_stat.full) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.seat_rd = 1'b1;
                    n_state       = S_SC_WR;
                end
            end
            S_SC_WR: begin
                o_cmd.seat_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.pipe_busy)
        else $error("Scan pipeline busy while the controller is idle.");

    a_scan_is_seat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_RUN) |-> !i_stat.is_leave)
        else $error("Scan running for a leave word.");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LV_CHK) |-> ($past(r_state) == S_LV_RD))
        else $error("Leave check without a preceding read.");

endmodule

FILE: hw/rtl/max_gap_seat_allocator_unit.sv
// Top level of the max-gap seat allocator.
//
//  Channel     | Direction | Signals                        | Contents
//  s_axis      | in        | tvalid, tready, tdata, tuser   | request word
//  m_axis      | out       | tvalid, tready, tdata, tuser   | answer word
//  cfg         | in        | valid, ready, data             | seat_count register
//
// A leave word is dispatched, its row read and checked, then the answer is loaded.
// A seat word scans one 16-seat row of the occupancy memory per cycle, then drains
// the scan pipeline and picks the seat in the widest gap; a refused seat word skips
// the write into the occupancy memory.
// One word is worked on at a time; the next is accepted while an answer waits.
// Reset is synchronous; per-row valid bits mark every seat free after reset.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps

module max_gap_seat_allocator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [15:0]                 i_s_axis_tdata,  // position
    input  logic                        i_s_axis_tuser,  // func
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [15:0]                 o_m_axis_tdata,  // assigned_seat
    output logic [1:0]                  o_m_axis_tuser,  // status
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mgsa_pkg::CNT_W-1:0]  i_cfg_data
);

    mgsa_pkg::t_cmd              cmd;
    mgsa_pkg::t_stat             stat;
    logic [mgsa_pkg::SEAT_W-1:0] out_seat;
    mgsa_pkg::t_status           out_status;

    assign o_cfg_ready = 1'b1;

    mgsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mgsa_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item_func  (mgsa_pkg::t_func'(i_s_axis_tuser)),
        .i_item_pos   (i_s_axis_tdata[mgsa_pkg::SEAT_W-1:0]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_seat   (out_seat),
        .o_out_status (out_status)
    );

    assign o_m_axis_tdata = {{(16 - mgsa_pkg::SEAT_W){1'b0}}, out_seat};
    assign o_m_axis_tuser = out_status;

endmodule
